// ===== rtl/ppurp_pkg.sv =====
// Shared constants, codes and types of the PPU register port.
package ppurp_pkg;

	localparam int VIDEO_MEM_BYTES = 16384;   // power of two
	localparam int VRAM_AW = $clog2(VIDEO_MEM_BYTES);
	localparam int OBJECT_MEM_BYTES = 256;
	localparam int OAM_AW = $clog2(OBJECT_MEM_BYTES);

	// event codes
	localparam logic [2:0] OP_READ         = 3'd0;
	localparam logic [2:0] OP_WRITE        = 3'd1;
	localparam logic [2:0] OP_VBLANK_START = 3'd2;
	localparam logic [2:0] OP_VBLANK_END   = 3'd3;
	localparam logic [2:0] OP_SPRITE_HIT   = 3'd4;

	// register numbers, $2000..$2007
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STAT   = 3'd2;
	localparam logic [2:0] REG_OAMADR = 3'd3;
	localparam logic [2:0] REG_OAMDAT = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	localparam int CTRL_NMI_BIT  = 7;
	localparam int CTRL_STEP_BIT = 2;

	localparam logic [15:0] STEP_ONE  = 16'd1;
	localparam logic [15:0] STEP_ROW  = 16'd32;
	localparam logic [13:0] PAL_BASE    = 14'h3F00;
	localparam logic [13:0] MIRROR_BASE = 14'h3000;
	localparam logic [13:0] MIRROR_CLR  = 14'h1000;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 64;

	typedef struct packed {
		logic       en;
		logic [4:0] addr;   // bit 4 selects the sprite palette
		logic [5:0] data;
	} pal_wr_t;

endpackage

// ===== rtl/ppurp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppurp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/ppurp_palette.sv =====
// Background and sprite palettes with the entry-zero mirror.
module ppurp_palette (
	input  logic               clk,
	input  logic               arst_n,
	input  ppurp_pkg::pal_wr_t wr,
	input  logic [4:0]         rd_addr,
	output logic [5:0]         rd_data
);

	logic [5:0] bg_q [16];
	logic [5:0] sp_q [16];
	logic [5:0] bg_n [16];
	logic [5:0] sp_n [16];

	always_comb begin
		bg_n = bg_q;
		sp_n = sp_q;
		if (wr.en) begin
			if (wr.addr[3:0] == 4'd0) begin
				bg_n[0] = wr.data;
				sp_n[0] = wr.data;
			end else if (!wr.addr[4]) begin
				bg_n[wr.addr[3:0]] = wr.data;
			end else begin
				sp_n[wr.addr[3:0]] = wr.data;
			end
			// entries 0, 4, 8 and C of both banks follow background entry 0
			bg_n[4]  = bg_n[0];
			bg_n[8]  = bg_n[0];
			bg_n[12] = bg_n[0];
			sp_n[0]  = bg_n[0];
			sp_n[4]  = bg_n[0];
			sp_n[8]  = bg_n[0];
			sp_n[12] = bg_n[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				bg_q[i] <= 6'd0;
				sp_q[i] <= 6'd0;
			end
		end else begin
			bg_q <= bg_n;
			sp_q <= sp_n;
		end
	end

	assign rd_data = rd_addr[4] ? sp_q[rd_addr[3:0]] : bg_q[rd_addr[3:0]];

endmodule

// ===== rtl/ppu_register_port.sv =====
// Top level of the PPU register port: register file, address logic, memories.
//
// channel  dir  tvalid/tready      tdata / tuser
// s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: reg_index, write_byte
// m_*      out  m_tvalid/m_tready  tdata: read_byte .. mask_value (59 bits used)
//
// One item per cycle while s_tready is high; each result shows in the cycle after its item is taken.
// The state update and memory access of an item complete at its accept edge;
// sprite memory read data comes straight from the RAM output register.
// s_tready is high whenever the result register is empty or being drained.
// Reset clears all registers and both palettes; VRAM and sprite memory hold
// whatever they held until written.
module ppu_register_port (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // reg_index[2:0], write_byte[10:3], zero pad
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // read_byte[7:0], nmi_pulse[8], vram_address[24:9],
	                               // temp_address[39:25], fine_scroll_x[42:40],
	                               // control_value[50:43], mask_value[58:51], zero pad
);

	logic        accept;
	logic [2:0]  opcode;
	logic [2:0]  reg_index;
	logic [7:0]  wbyte;

	logic [7:0]  ctrl_q, ctrl_n;
	logic [7:0]  mask_q, mask_n;
	logic        vbl_q, vbl_n;
	logic        hit_q, hit_n;
	logic        tog_q, tog_n;
	logic [15:0] scroll_q, scroll_n;
	logic [14:0] temp_q, temp_n;
	logic [2:0]  finex_q, finex_n;
	logic [7:0]  optr_q, optr_n;
	logic        latch_ok_q, latch_ok_n;

	logic        res_valid_q;
	logic [7:0]  res_byte_q;
	logic        res_oam_q;
	logic        res_nmi_q;

	logic [7:0]  rbyte;
	logic        rd_oam;
	logic        nmi;

	logic [13:0] port_addr;
	logic [13:0] vram_addr;
	logic [15:0] step;
	logic        is_pal;

	logic        vram_wr, vram_rd;
	logic        oam_wr, oam_rd;
	logic [7:0]  vram_rdata;
	logic [7:0]  oam_rdata;
	logic [7:0]  read_latch;

	ppurp_pkg::pal_wr_t pal_wr;
	logic [5:0]  pal_rdata;

	assign opcode    = s_tuser;
	assign reg_index = s_tdata[2:0];
	assign wbyte     = s_tdata[10:3];

	assign s_tready = !res_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign port_addr = scroll_q[13:0];
	assign is_pal    = port_addr >= ppurp_pkg::PAL_BASE;
	assign vram_addr = (port_addr >= ppurp_pkg::MIRROR_BASE) ?
	                   (port_addr & ~ppurp_pkg::MIRROR_CLR) : port_addr;
	assign step      = ctrl_q[ppurp_pkg::CTRL_STEP_BIT] ? ppurp_pkg::STEP_ROW
	                                                    : ppurp_pkg::STEP_ONE;
	// buffered data port: latch is the last VRAM read, zero before any
	assign read_latch = latch_ok_q ? vram_rdata : 8'd0;

	always_comb begin
		ctrl_n     = ctrl_q;
		mask_n     = mask_q;
		vbl_n      = vbl_q;
		hit_n      = hit_q;
		tog_n      = tog_q;
		scroll_n   = scroll_q;
		temp_n     = temp_q;
		finex_n    = finex_q;
		optr_n     = optr_q;
		latch_ok_n = latch_ok_q;
		rbyte      = 8'd0;
		rd_oam     = 1'b0;
		nmi        = 1'b0;
		vram_wr    = 1'b0;
		vram_rd    = 1'b0;
		oam_wr     = 1'b0;
		oam_rd     = 1'b0;
		pal_wr     = '{en: 1'b0, addr: port_addr[4:0], data: wbyte[5:0]};
		case (opcode)
			ppurp_pkg::OP_READ: begin
				case (reg_index)
					ppurp_pkg::REG_STAT: begin
						rbyte = {vbl_q, hit_q, 6'd0};
						vbl_n = 1'b0;
						tog_n = 1'b0;
					end
					ppurp_pkg::REG_OAMDAT: begin
						oam_rd = 1'b1;
						rd_oam = 1'b1;
						optr_n = optr_q + 8'd1;
					end
					ppurp_pkg::REG_DATA: begin
						scroll_n = scroll_q + step;
						if (is_pal) begin
							rbyte = {2'b00, pal_rdata};
						end else begin
							rbyte      = read_latch;
							vram_rd    = 1'b1;
							latch_ok_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ppurp_pkg::OP_WRITE: begin
				case (reg_index)
					ppurp_pkg::REG_CTRL: begin
						temp_n[11:10] = wbyte[1:0];
						nmi    = wbyte[ppurp_pkg::CTRL_NMI_BIT] &&
						         !ctrl_q[ppurp_pkg::CTRL_NMI_BIT] && vbl_q;
						ctrl_n = wbyte;
					end
					ppurp_pkg::REG_MASK: begin
						mask_n = wbyte;
					end
					ppurp_pkg::REG_OAMADR: begin
						optr_n = wbyte;
					end
					ppurp_pkg::REG_OAMDAT: begin
						oam_wr = 1'b1;
						optr_n = optr_q + 8'd1;
					end
					ppurp_pkg::REG_SCROLL: begin
						if (!tog_q) begin
							temp_n[4:0] = wbyte[7:3];
							finex_n     = wbyte[2:0];
						end else begin
							temp_n[9:5]   = wbyte[7:3];
							temp_n[14:12] = wbyte[2:0];
						end
						tog_n = !tog_q;
					end
					ppurp_pkg::REG_ADDR: begin
						if (!tog_q) begin
							temp_n[13:8] = wbyte[5:0];
							temp_n[14]   = 1'b0;
						end else begin
							temp_n[7:0] = wbyte;
							scroll_n    = {1'b0, temp_q[14:8], wbyte};
						end
						tog_n = !tog_q;
					end
					ppurp_pkg::REG_DATA: begin
						scroll_n = scroll_q + step;
						if (is_pal) begin
							pal_wr.en = 1'b1;
						end else begin
							vram_wr = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ppurp_pkg::OP_VBLANK_START: begin
				vbl_n = 1'b1;
				nmi   = ctrl_q[ppurp_pkg::CTRL_NMI_BIT];
			end
			ppurp_pkg::OP_VBLANK_END: begin
				vbl_n = 1'b0;
				hit_n = 1'b0;
			end
			ppurp_pkg::OP_SPRITE_HIT: begin
				hit_n = 1'b1;
			end
			default: begin
			end
		endcase
		// nothing moves unless an item is taken
		pal_wr.en = pal_wr.en && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= 8'd0;
			mask_q      <= 8'd0;
			vbl_q       <= 1'b0;
			hit_q       <= 1'b0;
			tog_q       <= 1'b0;
			scroll_q    <= 16'd0;
			temp_q      <= 15'd0;
			finex_q     <= 3'd0;
			optr_q      <= 8'd0;
			latch_ok_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_byte_q  <= 8'd0;
			res_oam_q   <= 1'b0;
			res_nmi_q   <= 1'b0;
		end else begin
			if (accept) begin
				ctrl_q      <= ctrl_n;
				mask_q      <= mask_n;
				vbl_q       <= vbl_n;
				hit_q       <= hit_n;
				tog_q       <= tog_n;
				scroll_q    <= scroll_n;
				temp_q      <= temp_n;
				finex_q     <= finex_n;
				optr_q      <= optr_n;
				latch_ok_q  <= latch_ok_n;
				res_valid_q <= 1'b1;
				res_byte_q  <= rbyte;
				res_oam_q   <= rd_oam;
				res_nmi_q   <= nmi;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	ppurp_ram #(
		.WIDTH(8),
		.DEPTH(ppurp_pkg::VIDEO_MEM_BYTES)
	) u_vram (
		.clk     (clk),
		.wr_en   (vram_wr && accept),
		.wr_addr (vram_addr[ppurp_pkg::VRAM_AW-1:0]),
		.wr_data (wbyte),
		.rd_en   (vram_rd && accept),
		.rd_addr (vram_addr[ppurp_pkg::VRAM_AW-1:0]),
		.rd_data (vram_rdata)
	);

	ppurp_ram #(
		.WIDTH(8),
		.DEPTH(ppurp_pkg::OBJECT_MEM_BYTES)
	) u_oam (
		.clk     (clk),
		.wr_en   (oam_wr && accept),
		.wr_addr (optr_q[ppurp_pkg::OAM_AW-1:0]),
		.wr_data (wbyte),
		.rd_en   (oam_rd && accept),
		.rd_addr (optr_q[ppurp_pkg::OAM_AW-1:0]),
		.rd_data (oam_rdata)
	);

	ppurp_palette u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_addr (port_addr[4:0]),
		.rd_data (pal_rdata)
	);

	// register state changes only with an accept, so it matches the held result
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {5'd0, mask_q, ctrl_q, finex_q, temp_q, scroll_q, res_nmi_q,
	                   res_oam_q ? oam_rdata : res_byte_q};

endmodule

// ===== rtl/ppurp_checker.sv =====
// Port-level checks of the PPU register port, bound to the top level.
module ppurp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	logic acc;

	assign acc = s_tvalid && s_tready;

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// every taken item gives a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid)
		else $error("no result after accepted item");

	// an NMI request is only made with NMI enabled in control
	a_nmi_en: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[50])
		else $error("nmi pulse with nmi disabled");

	// scroll address moves only with an item
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(m_tdata[24:9]))
		else $error("vram address changed without an item");

	// vblank end never requests NMI and leaves control alone
	a_vend: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == ppurp_pkg::OP_VBLANK_END |=>
			!m_tdata[8] && $stable(m_tdata[50:43]))
		else $error("vblank end misbehaved");

endmodule

bind ppu_register_port ppurp_checker u_ppurp_checker (.*);

// ===== tb/sv/ppu_register_port_test.sv =====
// Self-checking testbench for the PPU register port: directed and random bus traffic.
module ppu_register_port_test;
	import ppurp_pkg::*;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        nmi_pulse;
		logic [15:0] vram_address;
		logic [14:0] temp_address;
		logic [2:0]  fine_scroll_x;
		logic [7:0]  control_value;
		logic [7:0]  mask_value;
	} port_result_t;

	localparam int HOLD_CYCLES = 200;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // reg_index[2:0], write_byte[10:3], zero pad
	logic [2:0]  s_tuser = '0;   // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // read_byte, nmi_pulse, vram_address, temp_address,
	                             // fine_scroll_x, control_value, mask_value, zero pad

	ppu_register_port u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// predictor state
	logic [7:0]  ctl, msk, oam_ptr, read_buf;
	logic        in_vblank, hit_seen, second_write;
	logic [15:0] cur_addr;
	logic [14:0] tmp_addr;
	logic [2:0]  fine_x;
	logic [7:0]  vram [VIDEO_MEM_BYTES];
	bit          vram_written [VIDEO_MEM_BYTES];
	logic [7:0]  oam [OBJECT_MEM_BYTES];
	bit          oam_written [OBJECT_MEM_BYTES];
	logic [5:0]  bg_pal [16];
	logic [5:0]  spr_pal [16];

	port_result_t pending_results[$];

	int  errors = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  op_count [8];
	int  nmi_expected = 0;
	int  palette_hits = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  hold_request = 1'b0;
	bit  hold_active = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("ppu_register_port test failed");
		$finish;
	end

	task automatic report_error(string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR at result %0d: %s", results_checked, msg);
	endtask

	function automatic void clear_model();
		ctl = '0; msk = '0; oam_ptr = '0; read_buf = '0;
		in_vblank = 1'b0; hit_seen = 1'b0; second_write = 1'b0;
		cur_addr = '0; tmp_addr = '0; fine_x = '0;
		foreach (vram_written[i]) vram_written[i] = 1'b0;
		foreach (oam_written[i]) oam_written[i] = 1'b0;
		foreach (bg_pal[i]) begin
			bg_pal[i] = '0;
			spr_pal[i] = '0;
		end
		foreach (op_count[i]) op_count[i] = 0;
	endfunction

	// $3000-$3EFF folds onto $2000-$2EFF
	function automatic int vram_slot(logic [13:0] a);
		logic [13:0] m;
		m = (a >= MIRROR_BASE) ? (a & ~MIRROR_CLR) : a;
		return int'(m) % VIDEO_MEM_BYTES;
	endfunction

	function automatic logic [13:0] step_data_addr();
		logic [13:0] a;
		a = cur_addr[13:0];
		cur_addr = cur_addr + (ctl[CTRL_STEP_BIT] ? STEP_ROW : STEP_ONE);
		return a;
	endfunction

	function automatic bit read_hits_blank(logic [2:0] rn);
		if (rn == REG_OAMDAT)
			return !oam_written[oam_ptr];
		if (rn == REG_DATA && cur_addr[13:0] < PAL_BASE)
			return !vram_written[vram_slot(cur_addr[13:0])];
		return 1'b0;
	endfunction

	function automatic port_result_t predict_port_event(logic [2:0] op, logic [2:0] rn,
			logic [7:0] wb);
		port_result_t r;
		logic [13:0]  a;
		r = '0;
		case (op)
		OP_READ: begin
			case (rn)
			REG_STAT: begin
				r.read_byte = {in_vblank, hit_seen, 6'd0};
				in_vblank = 1'b0;
				second_write = 1'b0;
			end
			REG_OAMDAT: begin
				r.read_byte = oam[oam_ptr];
				oam_ptr++;
			end
			REG_DATA: begin
				r.read_byte = read_buf;
				a = step_data_addr();
				if (a >= PAL_BASE) begin
					// palette bypasses the read buffer
					r.read_byte = {2'b00, a[4] ? spr_pal[a[3:0]] : bg_pal[a[3:0]]};
					palette_hits++;
				end else
					read_buf = vram[vram_slot(a)];
			end
			default: ;
			endcase
		end
		OP_WRITE: begin
			case (rn)
			REG_CTRL: begin
				tmp_addr[11:10] = wb[1:0];
				r.nmi_pulse = wb[CTRL_NMI_BIT] && !ctl[CTRL_NMI_BIT] && in_vblank;
				ctl = wb;
			end
			REG_MASK: msk = wb;
			REG_OAMADR: oam_ptr = wb;
			REG_OAMDAT: begin
				oam[oam_ptr] = wb;
				oam_written[oam_ptr] = 1'b1;
				oam_ptr++;
			end
			REG_SCROLL: begin
				if (!second_write) begin
					tmp_addr[4:0] = wb[7:3];
					fine_x = wb[2:0];
				end else begin
					tmp_addr[9:5] = wb[7:3];
					tmp_addr[14:12] = wb[2:0];
				end
				second_write = !second_write;
			end
			REG_ADDR: begin
				if (!second_write)
					tmp_addr[14:8] = {1'b0, wb[5:0]};
				else begin
					tmp_addr[7:0] = wb;
					cur_addr = {1'b0, tmp_addr};
				end
				second_write = !second_write;
			end
			REG_DATA: begin
				a = step_data_addr();
				if (a >= PAL_BASE) begin
					palette_hits++;
					if (a[3:0] == 4'd0) begin
						bg_pal[0] = wb[5:0];
						spr_pal[0] = wb[5:0];
					end else if (!a[4])
						bg_pal[a[3:0]] = wb[5:0];
					else
						spr_pal[a[3:0]] = wb[5:0];
					// entry 0 shadows entries 4, 8 and C of both palettes
					for (int k = 0; k < 16; k += 4) begin
						bg_pal[k] = bg_pal[0];
						spr_pal[k] = bg_pal[0];
					end
				end else begin
					vram[vram_slot(a)] = wb;
					vram_written[vram_slot(a)] = 1'b1;
				end
			end
			default: ;
			endcase
		end
		OP_VBLANK_START: begin
			in_vblank = 1'b1;
			r.nmi_pulse = ctl[CTRL_NMI_BIT];
		end
		OP_VBLANK_END: begin
			in_vblank = 1'b0;
			hit_seen = 1'b0;
		end
		OP_SPRITE_HIT: hit_seen = 1'b1;
		default: ;
		endcase
		r.vram_address = cur_addr;
		r.temp_address = tmp_addr;
		r.fine_scroll_x = fine_x;
		r.control_value = ctl;
		r.mask_value = msk;
		return r;
	endfunction

	task automatic idle_for(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Leaves s_tvalid high unless it idles afterwards, so a following item can go out in the next cycle.
	task automatic send_item(logic [2:0] op, logic [2:0] rn, logic [7:0] wb);
		port_result_t r;
		// never read memory that has not been written; write it instead
		if (op == OP_READ && read_hits_blank(rn))
			op = OP_WRITE;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, wb, rn};
		do @(posedge clk); while (!s_tready);
		r = predict_port_event(op, rn, wb);
		pending_results.push_back(r);
		items_sent++;
		op_count[op]++;
		if (r.nmi_pulse)
			nmi_expected++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 15);
			if (gaps_on && $urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 6));
		end
	endtask

	// receiver: phases of steady, random, sparse and periodic ready, plus one long hold-off
	initial begin
		int mode, len, tick;
		tick = 0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				hold_active = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(4, 40);
				repeat (len) begin
					case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (tick % 4 != 3);
					endcase
					tick++;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		port_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_byte = m_tdata[7:0];
			got.nmi_pulse = m_tdata[8];
			got.vram_address = m_tdata[24:9];
			got.temp_address = m_tdata[39:25];
			got.fine_scroll_x = m_tdata[42:40];
			got.control_value = m_tdata[50:43];
			got.mask_value = m_tdata[58:51];
			if (pending_results.size() == 0)
				report_error("result with no item outstanding");
			else begin
				want = pending_results.pop_front();
				if (got.read_byte !== want.read_byte)
					report_error($sformatf("read_byte %h, expected %h",
						got.read_byte, want.read_byte));
				if (got.nmi_pulse !== want.nmi_pulse)
					report_error($sformatf("nmi_pulse %b, expected %b",
						got.nmi_pulse, want.nmi_pulse));
				if (got.vram_address !== want.vram_address)
					report_error($sformatf("vram_address %h, expected %h",
						got.vram_address, want.vram_address));
				if (got.temp_address !== want.temp_address)
					report_error($sformatf("temp_address %h, expected %h",
						got.temp_address, want.temp_address));
				if (got.fine_scroll_x !== want.fine_scroll_x)
					report_error($sformatf("fine_scroll_x %h, expected %h",
						got.fine_scroll_x, want.fine_scroll_x));
				if (got.control_value !== want.control_value)
					report_error($sformatf("control_value %h, expected %h",
						got.control_value, want.control_value));
				if (got.mask_value !== want.mask_value)
					report_error($sformatf("mask_value %h, expected %h",
						got.mask_value, want.mask_value));
			end
			results_checked++;
		end
	end

	task automatic test_registers();
		send_item(OP_WRITE, REG_MASK, 8'hFF);
		send_item(OP_WRITE, REG_SCROLL, 8'hFF);
		send_item(OP_WRITE, REG_SCROLL, 8'h00);
		send_item(OP_WRITE, REG_OAMADR, 8'hFF);
		send_item(OP_WRITE, REG_OAMDAT, 8'hA5);   // pointer wraps to 0
		send_item(OP_WRITE, REG_OAMADR, 8'hFF);
		send_item(OP_READ, REG_OAMDAT, 8'h00);
		send_item(OP_READ, REG_CTRL, 8'h00);      // write-only
		send_item(OP_WRITE, REG_STAT, 8'hFF);     // ignored
		send_item(3'($urandom_range(OP_SPRITE_HIT + 1, 7)), REG_DATA, 8'hFF);
	endtask

	task automatic test_data_port();
		send_item(OP_WRITE, REG_ADDR, 8'h30);
		send_item(OP_WRITE, REG_ADDR, 8'h00);
		send_item(OP_WRITE, REG_DATA, 8'hC3);     // mirrored onto $2000
		send_item(OP_WRITE, REG_CTRL, 8'h04);     // step 32
		send_item(OP_WRITE, REG_ADDR, 8'h20);
		send_item(OP_WRITE, REG_ADDR, 8'h00);
		send_item(OP_READ, REG_DATA, 8'h00);      // stale buffer, loads $2000
		send_item(OP_WRITE, REG_DATA, 8'h7E);     // $2020
		send_item(OP_WRITE, REG_ADDR, 8'h3F);
		send_item(OP_WRITE, REG_ADDR, 8'h10);
		send_item(OP_WRITE, REG_DATA, 8'hFF);     // sprite entry 0 = shared backdrop
		send_item(OP_READ, REG_DATA, 8'h00);      // $3F30: palette, unbuffered
		send_item(OP_WRITE, REG_ADDR, 8'h20);
		send_item(OP_WRITE, REG_ADDR, 8'h20);
		send_item(OP_READ, REG_DATA, 8'h00);
	endtask

	task automatic test_vblank_nmi();
		send_item(OP_WRITE, REG_CTRL, 8'h80);     // not in vblank: no pulse
		send_item(OP_VBLANK_START, REG_CTRL, 8'h00);
		send_item(OP_SPRITE_HIT, REG_CTRL, 8'h00);
		send_item(OP_READ, REG_STAT, 8'h00);
		send_item(OP_VBLANK_START, REG_CTRL, 8'h00);
		send_item(OP_WRITE, REG_CTRL, 8'h00);
		send_item(OP_WRITE, REG_CTRL, 8'h80);     // enable rises inside vblank
		send_item(OP_VBLANK_END, REG_CTRL, 8'h00);
	endtask

	task automatic test_output_stall();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		idle_for(1);
		while (!hold_active) @(posedge clk);
		for (int i = 0; i < 40; i++)
			send_item(i % 2 ? OP_READ : OP_WRITE, REG_OAMDAT, 8'($urandom));
		idle_for(1);
		while (hold_request) @(posedge clk);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic(int count);
		logic [7:0] vram_pages [7] = '{8'h00, 8'h07, 8'h20, 8'h23, 8'h2F, 8'h30, 8'h3E};
		int         stop, n, kind;
		logic [7:0] hi, lo;
		stop = items_sent + count;
		while (items_sent < stop) begin
			kind = $urandom_range(0, 99);
			n = $urandom_range(1, 8);
			lo = 8'($urandom);
			if (kind < 42) begin
				// write a run through the data port, then read it back
				if (kind < 30)
					hi = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h3E))
						: vram_pages[$urandom_range(0, 6)];
				else
					hi = 8'h3F;
				hi[7:6] = 2'($urandom);
				send_item(OP_READ, REG_STAT, 8'($urandom));
				if ($urandom_range(0, 2) == 0)
					send_item(OP_WRITE, REG_CTRL, 8'($urandom));
				send_item(OP_WRITE, REG_ADDR, hi);
				send_item(OP_WRITE, REG_ADDR, lo);
				repeat (n) send_item(OP_WRITE, REG_DATA, 8'($urandom));
				send_item(OP_WRITE, REG_ADDR, hi);
				send_item(OP_WRITE, REG_ADDR, lo);
				repeat (n + 1) send_item(OP_READ, REG_DATA, 8'($urandom));
			end else if (kind < 57) begin
				send_item(OP_WRITE, REG_OAMADR, lo);
				repeat (n) send_item(OP_WRITE, REG_OAMDAT, 8'($urandom));
				send_item(OP_WRITE, REG_OAMADR, lo);
				repeat (n) send_item(OP_READ, REG_OAMDAT, 8'($urandom));
			end else if (kind < 67) begin
				send_item(OP_READ, REG_STAT, 8'($urandom));
				send_item(OP_WRITE, REG_SCROLL, 8'($urandom));
				send_item(OP_WRITE, REG_SCROLL, 8'($urandom));
				send_item(OP_WRITE, REG_MASK, 8'($urandom));
			end else if (kind < 77) begin
				send_item(OP_VBLANK_START, 3'($urandom), 8'($urandom));
				repeat (n) begin
					case ($urandom_range(0, 3))
					0: send_item(OP_READ, REG_STAT, 8'($urandom));
					1: send_item(OP_WRITE, REG_CTRL, 8'($urandom));
					2: send_item(OP_SPRITE_HIT, 3'($urandom), 8'($urandom));
					default: send_item(OP_WRITE, REG_MASK, 8'($urandom));
					endcase
				end
				if ($urandom_range(0, 1))
					send_item(OP_VBLANK_END, 3'($urandom), 8'($urandom));
			end else
				send_item(3'($urandom), 3'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int guard;
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_data_port();
		test_vblank_nmi();
		test_output_stall();
		test_random_traffic(2000);

		idle_for(1);
		guard = 0;
		while (pending_results.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_results.size()));

		$display("Sent %0d items: %0d reads, %0d writes, %0d vblank/hit events, %0d unknown",
			items_sent, op_count[OP_READ], op_count[OP_WRITE],
			op_count[OP_VBLANK_START] + op_count[OP_VBLANK_END] + op_count[OP_SPRITE_HIT],
			items_sent - op_count[OP_READ] - op_count[OP_WRITE] - op_count[OP_VBLANK_START]
				- op_count[OP_VBLANK_END] - op_count[OP_SPRITE_HIT]);
		$display("Checked %0d results, %0d NMI pulses, %0d palette accesses, %0d errors",
			results_checked, nmi_expected, palette_hits, errors);
		if (errors == 0)
			$display("ppu_register_port test passed");
		else
			$display("ppu_register_port test failed");
		$finish;
	end

endmodule
